// ----- rtl/spg_pkg.sv -----
// Shared types, constants and arithmetic helpers for the smoothness penalty
// and gradient block. No dependencies.
package spg_pkg;

    // Field widths
    localparam int SAMPLE_W  = 32;
    localparam int LAMBDA_W  = 24;
    localparam int GRAD_W    = 48;
    localparam int PEN_W     = 64;
    localparam int CFG_IDX_W = 2;

    // Number of window cells
    localparam int N_CELLS = 4;

    // Results produced per sample at most
    localparam int MAX_RES = 3;

    // Second difference of three samples: 34 bits signed
    localparam int DIFF_W = SAMPLE_W + 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 2'd1;

    // Difference order
    localparam logic MODE_FIRST  = 1'b0;
    localparam logic MODE_SECOND = 1'b1;

    // Status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_SHORT = 1'b1;

    // Saturation limits
    localparam logic signed [PEN_W-1:0] GRAD_MAX_64 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [PEN_W-1:0] GRAD_MIN_64 = 64'shFFFF_8000_0000_0000;
    localparam logic signed [PEN_W-1:0] PEN_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;

    // One result transaction
    typedef struct packed {
        logic signed [GRAD_W-1:0] grad;
        logic signed [PEN_W-1:0]  penalty;
        logic                     last;
        logic                     status;
    } result_t;

    // Round Q.32 product to Q.16, ties toward +infinity
    function automatic logic signed [PEN_W-1:0] round16(input logic signed [PEN_W-1:0] x);
        logic signed [PEN_W-1:0] y;
        y = x + 64'sd32768;
        return y >>> 16;
    endfunction

    // Clamp to the 48-bit gradient range
    function automatic logic signed [GRAD_W-1:0] sat48(input logic signed [PEN_W-1:0] x);
        logic signed [PEN_W-1:0] y;
        if (x > GRAD_MAX_64) begin
            y = GRAD_MAX_64;
        end else if (x < GRAD_MIN_64) begin
            y = GRAD_MIN_64;
        end else begin
            y = x;
        end
        return y[GRAD_W-1:0];
    endfunction

    // a - 2b + c, exact
    function automatic logic signed [DIFF_W-1:0] sec_diff(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input logic signed [SAMPLE_W-1:0] c
    );
        logic signed [DIFF_W-1:0] ea;
        logic signed [DIFF_W-1:0] eb;
        logic signed [DIFF_W-1:0] ec;
        ea = DIFF_W'(a);
        eb = DIFF_W'(b);
        ec = DIFF_W'(c);
        return ea - (eb <<< 1) + ec;
    endfunction

endpackage

// ----- rtl/spg_cell.sv -----
// One window cell: holds a sample and its occupied flag, passes both to the
// next cell on every accepted transaction. Depends on spg_pkg.
module spg_cell (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 shift,
    input  logic                                 clear,
    input  logic signed [spg_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic                                 occ_in,
    output logic signed [spg_pkg::SAMPLE_W-1:0]  sample_out,
    output logic                                 occ_out
);

    logic signed [spg_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                occ_reg;
    logic                                occ_next;

    // Occupancy drops to empty at the end of a vector
    always_comb begin
        occ_next = occ_reg;
        if (shift) begin
            occ_next = clear ? 1'b0 : occ_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    // Sample only matters while occupied
    always_ff @(posedge aclk) begin
        if (shift) begin
            sample_reg <= sample_in;
        end
    end

    assign sample_out = sample_reg;
    assign occ_out    = occ_reg;

endmodule

// ----- rtl/spg_emit.sv -----
// Output stage: holds the up to three results of a sample and hands them
// out one per transaction. Depends on spg_pkg.
module spg_emit (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      load_valid,
    output logic                                      load_ready,
    input  logic [1:0]                                load_count,
    input  spg_pkg::result_t [spg_pkg::MAX_RES-1:0]   load_res,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output spg_pkg::result_t                          m_res
);

    logic [1:0]                               cnt_reg;
    logic [1:0]                               cnt_next;
    spg_pkg::result_t [spg_pkg::MAX_RES-1:0]  slot_reg;
    spg_pkg::result_t [spg_pkg::MAX_RES-1:0]  slot_next;
    logic                                     fire;

    assign fire       = (cnt_reg != 2'd0) && m_ready;
    assign load_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);

    // Load a new set once the last pending result leaves, else shift down
    always_comb begin
        cnt_next  = cnt_reg;
        slot_next = slot_reg;
        if (load_valid && load_ready) begin
            cnt_next  = load_count;
            slot_next = load_res;
        end else if (fire) begin
            cnt_next = cnt_reg - 2'd1;
            for (int k = 0; k < spg_pkg::MAX_RES - 1; k++) begin
                slot_next[k] = slot_reg[k+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign m_valid = (cnt_reg != 2'd0);
    assign m_res   = slot_reg[0];

endmodule

// ----- rtl/smoothness_penalty_gradient_top.sv -----
// Top level of the smoothness penalty and gradient block: window cell chain,
// four-stage arithmetic pipeline and output stage. Depends on spg_pkg,
// spg_cell and spg_emit.
// An accepted sample passes stage registers s1 to s4 and then the output register.
// Throughput: one sample per cycle unless m_ready stalls; the final sample of a
// second-order vector gives three results, handed out one per transaction while input stalls.
// Reset: lambda 0, first-order mode, window empty, square sum 0, pipeline
// and output register empty.
module smoothness_penalty_gradient_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // sample channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [spg_pkg::SAMPLE_W-1:0]   s_beta,
    input  logic                                  s_in_last,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [spg_pkg::GRAD_W-1:0]     m_grad,
    output logic signed [spg_pkg::PEN_W-1:0]      m_penalty,
    output logic                                  m_out_last,
    output logic                                  m_status,
    // configuration channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [spg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [spg_pkg::LAMBDA_W-1:0]          cfg_data
);

    localparam int SW     = spg_pkg::SAMPLE_W;
    localparam int LW     = spg_pkg::LAMBDA_W;
    localparam int DW     = spg_pkg::DIFF_W;
    localparam int EW     = DW + 3;               // difference of differences
    localparam int PW     = spg_pkg::PEN_W;
    localparam int GPW    = EW + LW + 1;          // lambda times EW-bit term
    localparam int SQW    = 2 * DW;               // exact square
    localparam int TW     = SQW - 16;             // square in Q.16
    localparam int DFW    = SW + 1;               // last minus first
    localparam int PDW    = DFW + LW + 1;         // lambda times that
    localparam int SUMW   = PW - 1;               // square sum, unsigned
    localparam int HIW    = SUMW - 32;            // upper part of square sum
    localparam int TOPW   = LW + HIW;
    localparam int LOWW   = LW + 32;
    localparam int NC     = spg_pkg::N_CELLS;

    typedef struct packed {
        logic last;
        logic mode;
        logic first;      // first sample of the vector
        logic ge2;        // at least two samples before this one
        logic short_vec;  // fewer than three samples before this one
    } flags_t;

    typedef struct packed {
        logic signed [EW-1:0]  e_mid;
        logic signed [EW-1:0]  e_b;
        logic signed [EW-1:0]  e_c;
        logic [DW-1:0]         mag2;
        logic signed [DFW-1:0] diff;
        flags_t                flags;
    } s1_t;

    typedef struct packed {
        logic signed [GPW-1:0] pa;
        logic signed [GPW-1:0] pb;
        logic signed [GPW-1:0] pc;
        logic [TW-1:0]         t;
        logic signed [PDW-1:0] pdiff;
        flags_t                flags;
    } s2_t;

    typedef struct packed {
        logic signed [spg_pkg::GRAD_W-1:0] ga;
        logic signed [spg_pkg::GRAD_W-1:0] gb;
        logic signed [spg_pkg::GRAD_W-1:0] gc;
        logic signed [PW-1:0]              pen1;
        logic [SUMW-1:0]                   ssum;
        flags_t                            flags;
    } s3_t;

    typedef struct packed {
        logic signed [spg_pkg::GRAD_W-1:0] ga;
        logic signed [spg_pkg::GRAD_W-1:0] gb;
        logic signed [spg_pkg::GRAD_W-1:0] gc;
        logic signed [PW-1:0]              pen1;
        logic [TOPW-1:0]                   top;
        logic [LOWW-1:0]                   low;
        flags_t                            flags;
    } s4_t;

    // Configuration registers
    logic [LW-1:0] lambda_reg;
    logic          order_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lambda_reg <= '0;
            order_reg  <= spg_pkg::MODE_FIRST;
        end else if (cfg_valid) begin
            case (cfg_index)
                spg_pkg::CFG_LAMBDA: lambda_reg <= cfg_data;
                spg_pkg::CFG_ORDER:  order_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline handshake: a stage loads when empty or when it empties forward
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ld1, ld2, ld3, ld4, emit_ready;
    logic accept;

    assign ld4    = !v4_reg || emit_ready;
    assign ld3    = !v3_reg || ld4;
    assign ld2    = !v2_reg || ld3;
    assign ld1    = !v1_reg || ld2;
    assign s_ready = ld1;
    assign accept = s_valid && ld1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg <= s_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
        end
    end

    // Window cell chain, newest sample in cell 0
    logic signed [SW-1:0] chain_sample [NC+1];
    logic                 chain_occ    [NC+1];

    assign chain_sample[0] = s_beta;
    assign chain_occ[0]    = 1'b1;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        spg_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .shift      (accept),
            .clear      (s_in_last),
            .sample_in  (chain_sample[k]),
            .occ_in     (chain_occ[k]),
            .sample_out (chain_sample[k+1]),
            .occ_out    (chain_occ[k+1])
        );
    end

    // First sample of the vector
    logic signed [SW-1:0] first_reg;

    always_ff @(posedge aclk) begin
        if (accept && !chain_occ[1]) begin
            first_reg <= s_beta;
        end
    end

    // Stage 0: second differences over the window
    logic signed [DW-1:0] d0, d1, d2;
    s1_t                  s1_next, s1_reg;

    always_comb begin
        d0 = chain_occ[4] ? spg_pkg::sec_diff(chain_sample[4], chain_sample[3],
                                              chain_sample[2]) : '0;
        d1 = chain_occ[3] ? spg_pkg::sec_diff(chain_sample[3], chain_sample[2],
                                              chain_sample[1]) : '0;
        d2 = chain_occ[2] ? spg_pkg::sec_diff(chain_sample[2], chain_sample[1],
                                              s_beta) : '0;
        s1_next.e_mid = EW'(d2) - (EW'(d1) <<< 1) + EW'(d0);
        s1_next.e_b   = EW'(d1) - (EW'(d2) <<< 1);
        s1_next.e_c   = EW'(d2);
        s1_next.mag2  = d2[DW-1] ? DW'(-d2) : DW'(d2);
        s1_next.diff  = DFW'(s_beta) - DFW'(first_reg);
        s1_next.flags.last      = s_in_last;
        s1_next.flags.mode      = order_reg;
        s1_next.flags.first     = !chain_occ[1];
        s1_next.flags.ge2       = chain_occ[2];
        s1_next.flags.short_vec = !chain_occ[3];
    end

    always_ff @(posedge aclk) begin
        if (ld1) s1_reg <= s1_next;
    end

    // Stage 1: products with lambda and the square of the newest difference
    logic signed [LW:0]    lam_s;
    logic [SQW-1:0]        sq;
    logic [SQW-1:0]        sq_rnd;
    s2_t                   s2_next, s2_reg;

    assign lam_s = signed'({1'b0, lambda_reg});

    always_comb begin
        s2_next.pa    = GPW'(lam_s) * GPW'(signed'(s1_reg.e_mid));
        s2_next.pb    = GPW'(lam_s) * GPW'(signed'(s1_reg.e_b));
        s2_next.pc    = GPW'(lam_s) * GPW'(signed'(s1_reg.e_c));
        sq            = SQW'(s1_reg.mag2) * SQW'(s1_reg.mag2);
        sq_rnd        = sq + SQW'(32768);
        s2_next.t     = TW'(sq_rnd >> 16);
        s2_next.pdiff = PDW'(lam_s) * PDW'(signed'(s1_reg.diff));
        s2_next.flags = s1_reg.flags;
    end

    always_ff @(posedge aclk) begin
        if (ld2) s2_reg <= s2_next;
    end

    // Stage 2: rounding and the running square sum
    logic [SUMW-1:0] acc_reg, acc_next;
    logic [PW-1:0]   acc_sum;
    s3_t             s3_next, s3_reg;

    always_comb begin
        s3_next.ga   = spg_pkg::sat48(spg_pkg::round16(PW'(signed'(s2_reg.pa)) <<< 1));
        s3_next.gb   = spg_pkg::sat48(spg_pkg::round16(PW'(signed'(s2_reg.pb)) <<< 1));
        s3_next.gc   = spg_pkg::sat48(spg_pkg::round16(PW'(signed'(s2_reg.pc)) <<< 1));
        s3_next.pen1 = spg_pkg::round16(PW'(signed'(s2_reg.pdiff)));
        acc_sum      = PW'(acc_reg) + PW'(s2_reg.t);
        s3_next.ssum = acc_sum[PW-1] ? '1 : acc_sum[SUMW-1:0];
        s3_next.flags = s2_reg.flags;
        acc_next = acc_reg;
        if (v2_reg && ld3) begin
            acc_next = s2_reg.flags.last ? '0 : s3_next.ssum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld3) s3_reg <= s3_next;
    end

    // Stage 3: lambda times the square sum, in two halves
    s4_t s4_next, s4_reg;

    always_comb begin
        s4_next.ga    = s3_reg.ga;
        s4_next.gb    = s3_reg.gb;
        s4_next.gc    = s3_reg.gc;
        s4_next.pen1  = s3_reg.pen1;
        s4_next.top   = TOPW'(lambda_reg) * TOPW'(s3_reg.ssum[SUMW-1:32]);
        s4_next.low   = LOWW'(lambda_reg) * LOWW'(s3_reg.ssum[31:0]);
        s4_next.flags = s3_reg.flags;
    end

    always_ff @(posedge aclk) begin
        if (ld4) s4_reg <= s4_next;
    end

    // Stage 4: second-order penalty and the result set
    logic [LOWW:0]                             low_rnd;
    logic [PW-1:0]                             pen_sum;
    logic signed [PW-1:0]                      pen2;
    spg_pkg::result_t [spg_pkg::MAX_RES-1:0]   res_set;
    spg_pkg::result_t                          res_short;
    logic [1:0]                                res_count;
    flags_t                                    f4;

    always_comb begin
        low_rnd = (LOWW+1)'(s4_reg.low) + (LOWW+1)'(32768);
        pen_sum = {1'b0, s4_reg.top[46:0], 16'd0} + PW'(low_rnd >> 16);
        if ((|s4_reg.top[TOPW-1:47]) || pen_sum[PW-1]) begin
            pen2 = spg_pkg::PEN_MAX;
        end else begin
            pen2 = signed'(pen_sum);
        end
    end

    always_comb begin
        f4 = s4_reg.flags;
        res_short.grad    = '0;
        res_short.penalty = '0;
        res_short.last    = 1'b1;
        res_short.status  = spg_pkg::STATUS_SHORT;
        for (int k = 0; k < spg_pkg::MAX_RES; k++) begin
            res_set[k].grad    = '0;
            res_set[k].penalty = '0;
            res_set[k].last    = 1'b0;
            res_set[k].status  = spg_pkg::STATUS_OK;
        end
        res_count = 2'd0;
        if (f4.mode == spg_pkg::MODE_FIRST) begin
            res_count = 2'd1;
            if (f4.last) begin
                if (f4.first) begin
                    res_set[0] = res_short;
                end else begin
                    res_set[0].grad    = spg_pkg::GRAD_W'(lambda_reg);
                    res_set[0].penalty = s4_reg.pen1;
                    res_set[0].last    = 1'b1;
                end
            end else if (f4.first) begin
                res_set[0].grad = -spg_pkg::GRAD_W'(lambda_reg);
            end
        end else begin
            if (f4.last) begin
                if (f4.short_vec) begin
                    res_count  = 2'd1;
                    res_set[0] = res_short;
                end else begin
                    res_count          = 2'd3;
                    res_set[0].grad    = s4_reg.ga;
                    res_set[1].grad    = s4_reg.gb;
                    res_set[2].grad    = s4_reg.gc;
                    res_set[2].penalty = pen2;
                    res_set[2].last    = 1'b1;
                end
            end else if (f4.ge2) begin
                res_count       = 2'd1;
                res_set[0].grad = s4_reg.ga;
            end
        end
    end

    // Output register
    spg_pkg::result_t m_res;

    spg_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (v4_reg),
        .load_ready (emit_ready),
        .load_count (res_count),
        .load_res   (res_set),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (m_res)
    );

    assign m_grad     = m_res.grad;
    assign m_penalty  = m_res.penalty;
    assign m_out_last = m_res.last;
    assign m_status   = m_res.status;

endmodule
